// File: hw/rtl/chunked_bump_allocator_macros.svh
// Assertion macros used by the chunked bump allocator RTL.
`ifndef CHUNKED_BUMP_ALLOCATOR_MACROS_SVH
`define CHUNKED_BUMP_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define CBA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chunked_bump_allocator: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chunked_bump_allocator: assertion failed");

`else

`define CBA_ASSERT_SAME(label, clk, rst, ante, cons)
`define CBA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/cba_pkg.sv
// Types, codes and constants of the chunked bump allocator.
`timescale 1ns / 1ps
`default_nettype none

package cba_pkg;

   // Defaults of the top-level parameters.
   localparam int CHUNK_SLOTS_DEFAULT = 64;
   localparam int OFFSET_BITS_DEFAULT = 32;
   localparam int SIZE_BITS_DEFAULT   = 24;

   // Fixed widths of the port fields.
   localparam int ACTION_BITS     = 2;
   localparam int REQ_BYTES_BITS  = 24;
   localparam int VADDR_BITS      = 32;
   localparam int STATUS_BITS     = 3;
   localparam int CHUNK_NUM_BITS  = 6;
   localparam int IN_CHUNK_BITS   = 24;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 24;
   localparam int CHUNKS_REG_BITS = 7;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEFAULT_CHUNK_BYTES = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHUNKS_IN_USE       = 2'd1;

   // Register reset values.
   localparam logic [CSR_DATA_BITS-1:0]   RESET_DEFAULT_CHUNK_BYTES = 24'd4096;
   localparam logic [CHUNKS_REG_BITS-1:0] RESET_CHUNKS_IN_USE       = 7'd64;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_ALLOCATE = 2'd0,
      ACT_LOOKUP   = 2'd1,
      ACT_FINALIZE = 2'd2,
      ACT_CLEAR    = 2'd3
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STS_OK        = 3'd0,
      STS_NO_CHUNK  = 3'd1,
      STS_NOT_FOUND = 3'd2,
      STS_ZERO_SIZE = 3'd3,
      STS_OVERFLOW  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_LCACHE,
      ST_LSCAN,
      ST_SIMPLE
   } state_type;

endpackage

`default_nettype wire

// File: hw/rtl/cba_end_mem.sv
// Chunk end-offset memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cba_end_mem #(
   parameter int DEPTH     = cba_pkg::CHUNK_SLOTS_DEFAULT,
   parameter int WIDTH     = cba_pkg::OFFSET_BITS_DEFAULT,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // No reset: entries above the fill mark are never used by the allocator.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/chunked_bump_allocator.sv
// Chunked bump allocator with virtual offset translation: top level.
//
// One request is worked on at a time. Allocate, finalize and clear pass through
// one working state (ST_ALLOC or ST_SIMPLE) before the result is registered; a
// lookup that hits the one-entry cache passes only through ST_LCACHE. A lookup
// that misses walks the chunk table from the current chunk downward in
// ST_LSCAN, one entry per cycle while the response output is free, through the
// single read port of the end-offset memory; when no table entry is usable at
// all, it ends in ST_LCACHE with not found. A new request is taken while the
// previous result still waits on rsp_ready; the block stalls only when a second
// result is ready before the first is taken.
// Chunk table entries are valid up to the current chunk, so no clearing pass
// runs after reset or clear. Configuration writes are always accepted;
// chunks_in_use takes effect at reset and at the next clear request.
`timescale 1ns / 1ps
`default_nettype none
`include "chunked_bump_allocator_macros.svh"

module chunked_bump_allocator #(
   parameter int CHUNK_SLOTS = cba_pkg::CHUNK_SLOTS_DEFAULT,
   parameter int OFFSET_BITS = cba_pkg::OFFSET_BITS_DEFAULT,
   parameter int SIZE_BITS   = cba_pkg::SIZE_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [cba_pkg::ACTION_BITS-1:0]     req_action,
   input  wire logic [cba_pkg::REQ_BYTES_BITS-1:0]  req_request_bytes,
   input  wire logic [cba_pkg::VADDR_BITS-1:0]      req_virtual_address,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [cba_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic      [cba_pkg::VADDR_BITS-1:0]      rsp_granted_offset,
   output logic      [cba_pkg::CHUNK_NUM_BITS-1:0]  rsp_chunk_number,
   output logic      [cba_pkg::IN_CHUNK_BITS-1:0]   rsp_offset_in_chunk,
   output logic                                     rsp_cache_hit,

   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cba_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [cba_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int CW = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
   localparam int UW = $clog2(CHUNK_SLOTS + 1);
   localparam int XW = UW + 1;
   localparam int AW = ((OFFSET_BITS > SIZE_BITS) ? OFFSET_BITS : SIZE_BITS) + 1;
   localparam int USABLE_RESET =
      (int'(cba_pkg::RESET_CHUNKS_IN_USE) > CHUNK_SLOTS) ? CHUNK_SLOTS
                                                         : int'(cba_pkg::RESET_CHUNKS_IN_USE);

   // Control state.
   cba_pkg::state_type                    state_ff, state_in;
   logic [CW-1:0]                         cur_ff, cur_in;
   logic                                  opened_ff, opened_in;
   logic [SIZE_BITS-1:0]                  free_ff, free_in;
   logic [SIZE_BITS-1:0]                  total_ff, total_in;
   logic [UW-1:0]                         usable_ff, usable_in;
   logic                                  cache_valid_ff, cache_valid_in;
   logic [CW-1:0]                         cache_chunk_ff, cache_chunk_in;
   logic [cba_pkg::CSR_DATA_BITS-1:0]     dflt_ff, dflt_in;
   logic [cba_pkg::CHUNKS_REG_BITS-1:0]   chunks_in_use_ff, chunks_in_use_in;
   logic                                  rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [OFFSET_BITS-1:0]                cache_low_ff, cache_low_in;
   logic [OFFSET_BITS-1:0]                cache_high_ff, cache_high_in;
   cba_pkg::action_type                   act_ff, act_in;
   logic [SIZE_BITS-1:0]                  size_ff, size_in;
   logic [OFFSET_BITS-1:0]                va_ff, va_in;
   logic [CW-1:0]                         idx_ff, idx_in;
   logic [OFFSET_BITS-1:0]                hi_ff, hi_in;
   cba_pkg::status_type                   rsp_status_ff, rsp_status_in;
   logic [cba_pkg::VADDR_BITS-1:0]        rsp_granted_ff, rsp_granted_in;
   logic [cba_pkg::CHUNK_NUM_BITS-1:0]    rsp_chunk_ff, rsp_chunk_in;
   logic [cba_pkg::IN_CHUNK_BITS-1:0]     rsp_inner_ff, rsp_inner_in;
   logic                                  rsp_hit_ff, rsp_hit_in;
   logic                                  rsp_load;

   // Memory port.
   logic                                  rd_en;
   logic [CW-1:0]                         rd_addr;
   logic [OFFSET_BITS-1:0]                rd_data;
   logic                                  wr_en;
   logic [CW-1:0]                         wr_addr;

   // Datapath terms.
   logic                                  out_free;
   logic                                  cur_below;
   logic                                  next_below;
   logic                                  fits;
   logic [OFFSET_BITS-1:0]                start_off;
   logic [AW-1:0]                         end_sum;
   logic                                  overflow;
   logic [SIZE_BITS-1:0]                  dflt_size;
   logic [SIZE_BITS-1:0]                  new_size;
   logic                                  cache_match;
   logic [OFFSET_BITS-1:0]                scan_low;
   logic                                  scan_match;
   logic [UW-1:0]                         usable_clamp;

   cba_end_mem #(
      .DEPTH    (CHUNK_SLOTS),
      .WIDTH    (OFFSET_BITS),
      .ADDR_BITS(CW)
   ) u_end_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(end_sum[OFFSET_BITS-1:0]),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cur_below  = XW'(cur_ff) < XW'(usable_ff);
   assign next_below = (XW'(cur_ff) + XW'(1)) < XW'(usable_ff);
   assign fits       = opened_ff && (size_ff <= free_ff);
   // An unopened current chunk only occurs as chunk 0 of an empty table.
   assign start_off  = opened_ff ? rd_data : '0;
   assign end_sum    = AW'(start_off) + AW'(size_ff);
   assign overflow   = |end_sum[AW-1:OFFSET_BITS];
   assign dflt_size  = SIZE_BITS'(dflt_ff);
   assign new_size   = (size_ff > dflt_size) ? size_ff : dflt_size;
   assign cache_match = cache_valid_ff && (va_ff >= cache_low_ff) && (va_ff < cache_high_ff);
   assign scan_low   = (idx_ff == '0) ? '0 : rd_data;
   assign scan_match = (va_ff < hi_ff) && (va_ff >= scan_low);
   assign usable_clamp = (int'(chunks_in_use_ff) > CHUNK_SLOTS) ? UW'(CHUNK_SLOTS)
                                                                : UW'(chunks_in_use_ff);

   assign csr_ready = 1'b1;

   always_comb begin
      logic [CW-1:0]        alloc_idx;
      logic [SIZE_BITS-1:0] base_free;

      alloc_idx      = cur_ff;
      base_free      = free_ff;

      state_in       = state_ff;
      cur_in         = cur_ff;
      opened_in      = opened_ff;
      free_in        = free_ff;
      total_in       = total_ff;
      usable_in      = usable_ff;
      cache_valid_in = cache_valid_ff;
      cache_chunk_in = cache_chunk_ff;
      cache_low_in   = cache_low_ff;
      cache_high_in  = cache_high_ff;
      act_in         = act_ff;
      size_in        = size_ff;
      va_in          = va_ff;
      idx_in         = idx_ff;
      hi_in          = hi_ff;

      dflt_in          = dflt_ff;
      chunks_in_use_in = chunks_in_use_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == cba_pkg::REG_DEFAULT_CHUNK_BYTES) begin
            dflt_in = csr_wdata;
         end else if (csr_index == cba_pkg::REG_CHUNKS_IN_USE) begin
            chunks_in_use_in = csr_wdata[cba_pkg::CHUNKS_REG_BITS-1:0];
         end
      end

      req_ready = (state_ff == cba_pkg::ST_IDLE);
      rd_en     = 1'b0;
      rd_addr   = cur_ff;
      wr_en     = 1'b0;
      wr_addr   = cur_ff;

      rsp_load       = 1'b0;
      rsp_status_in  = cba_pkg::STS_OK;
      rsp_granted_in = '0;
      rsp_chunk_in   = '0;
      rsp_inner_in   = '0;
      rsp_hit_in     = 1'b0;

      unique case (state_ff)
         cba_pkg::ST_IDLE: begin
            if (req_valid) begin
               act_in  = cba_pkg::action_type'(req_action);
               size_in = SIZE_BITS'(req_request_bytes);
               va_in   = OFFSET_BITS'(req_virtual_address);
               unique case (cba_pkg::action_type'(req_action))
                  cba_pkg::ACT_ALLOCATE: begin
                     rd_en    = 1'b1;
                     state_in = cba_pkg::ST_ALLOC;
                  end
                  cba_pkg::ACT_LOOKUP: begin
                     rd_en    = 1'b1;
                     state_in = cba_pkg::ST_LCACHE;
                  end
                  cba_pkg::ACT_FINALIZE,
                  cba_pkg::ACT_CLEAR: begin
                     state_in = cba_pkg::ST_SIMPLE;
                  end
               endcase
            end
         end

         cba_pkg::ST_ALLOC: begin
            if (out_free) begin
               state_in = cba_pkg::ST_IDLE;
               rsp_load = 1'b1;
               priority if (size_ff == '0) begin
                  rsp_status_in = cba_pkg::STS_ZERO_SIZE;
               end else if (!cur_below) begin
                  rsp_status_in = cba_pkg::STS_NO_CHUNK;
               end else if (opened_ff && !fits && !next_below) begin
                  // No room for a next chunk: trim the current one anyway.
                  if (free_ff != '0) begin
                     total_in = total_ff - free_ff;
                     free_in  = '0;
                  end
                  rsp_status_in = cba_pkg::STS_NO_CHUNK;
               end else if (overflow) begin
                  rsp_status_in = cba_pkg::STS_OVERFLOW;
               end else begin
                  if (!fits) begin
                     // Trimming the old chunk is subsumed by the new totals.
                     if (opened_ff) begin
                        alloc_idx = cur_ff + CW'(1);
                        cur_in    = alloc_idx;
                     end
                     opened_in = 1'b1;
                     total_in  = new_size;
                     base_free = new_size;
                  end
                  wr_en   = 1'b1;
                  wr_addr = alloc_idx;
                  free_in = base_free - size_ff;
                  if (cache_valid_ff && (cache_chunk_ff == alloc_idx)) begin
                     cache_high_in = end_sum[OFFSET_BITS-1:0];
                  end
                  rsp_granted_in = cba_pkg::VADDR_BITS'(start_off);
                  rsp_chunk_in   = cba_pkg::CHUNK_NUM_BITS'(alloc_idx);
               end
            end
         end

         cba_pkg::ST_LCACHE: begin
            if (out_free) begin
               priority if (cache_match) begin
                  state_in      = cba_pkg::ST_IDLE;
                  rsp_load      = 1'b1;
                  rsp_chunk_in  = cba_pkg::CHUNK_NUM_BITS'(cache_chunk_ff);
                  rsp_inner_in  = cba_pkg::IN_CHUNK_BITS'(va_ff - cache_low_ff);
                  rsp_hit_in    = 1'b1;
               end else if (!cur_below) begin
                  state_in      = cba_pkg::ST_IDLE;
                  rsp_load      = 1'b1;
                  rsp_status_in = cba_pkg::STS_NOT_FOUND;
               end else begin
                  // Start the walk at the current chunk; fetch its lower bound.
                  hi_in    = start_off;
                  idx_in   = cur_ff;
                  rd_en    = (cur_ff != '0);
                  rd_addr  = cur_ff - CW'(1);
                  state_in = cba_pkg::ST_LSCAN;
               end
            end
         end

         cba_pkg::ST_LSCAN: begin
            if (out_free) begin
               priority if (scan_match) begin
                  state_in       = cba_pkg::ST_IDLE;
                  rsp_load       = 1'b1;
                  rsp_chunk_in   = cba_pkg::CHUNK_NUM_BITS'(idx_ff);
                  rsp_inner_in   = cba_pkg::IN_CHUNK_BITS'(va_ff - scan_low);
                  cache_valid_in = 1'b1;
                  cache_chunk_in = idx_ff;
                  cache_low_in   = scan_low;
                  cache_high_in  = hi_ff;
               end else if (idx_ff == '0) begin
                  state_in      = cba_pkg::ST_IDLE;
                  rsp_load      = 1'b1;
                  rsp_status_in = cba_pkg::STS_NOT_FOUND;
               end else begin
                  hi_in   = rd_data;
                  idx_in  = idx_ff - CW'(1);
                  rd_en   = (idx_ff != CW'(1));
                  rd_addr = idx_ff - CW'(2);
               end
            end
         end

         cba_pkg::ST_SIMPLE: begin
            if (out_free) begin
               state_in = cba_pkg::ST_IDLE;
               rsp_load = 1'b1;
               if (act_ff == cba_pkg::ACT_CLEAR) begin
                  cur_in         = '0;
                  opened_in      = 1'b0;
                  free_in        = '0;
                  total_in       = '0;
                  cache_valid_in = 1'b0;
                  cache_chunk_in = '0;
                  cache_low_in   = '0;
                  cache_high_in  = '0;
                  usable_in      = usable_clamp;
               end else if ((free_ff != '0) && cur_below) begin
                  total_in = total_ff - free_ff;
                  free_in  = '0;
               end
            end
         end

         default: begin
            state_in = cba_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || rsp_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= cba_pkg::ST_IDLE;
         cur_ff           <= '0;
         opened_ff        <= 1'b0;
         free_ff          <= '0;
         total_ff         <= '0;
         usable_ff        <= UW'(USABLE_RESET);
         cache_valid_ff   <= 1'b0;
         cache_chunk_ff   <= '0;
         dflt_ff          <= cba_pkg::RESET_DEFAULT_CHUNK_BYTES;
         chunks_in_use_ff <= cba_pkg::RESET_CHUNKS_IN_USE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cur_ff           <= cur_in;
         opened_ff        <= opened_in;
         free_ff          <= free_in;
         total_ff         <= total_in;
         usable_ff        <= usable_in;
         cache_valid_ff   <= cache_valid_in;
         cache_chunk_ff   <= cache_chunk_in;
         dflt_ff          <= dflt_in;
         chunks_in_use_ff <= chunks_in_use_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cache_low_ff  <= cache_low_in;
      cache_high_ff <= cache_high_in;
      act_ff        <= act_in;
      size_ff       <= size_in;
      va_ff         <= va_in;
      idx_ff        <= idx_in;
      hi_ff         <= hi_in;
      if (rsp_load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_granted_ff <= rsp_granted_in;
         rsp_chunk_ff   <= rsp_chunk_in;
         rsp_inner_ff   <= rsp_inner_in;
         rsp_hit_ff     <= rsp_hit_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_offset  = rsp_granted_ff;
   assign rsp_chunk_number    = rsp_chunk_ff;
   assign rsp_offset_in_chunk = rsp_inner_ff;
   assign rsp_cache_hit       = rsp_hit_ff;

   // An opened current chunk always lies inside the usable part of the table.
   `CBA_ASSERT_SAME(a_open_chunk_usable, clock, reset, opened_ff, XW'(cur_ff) < XW'(usable_ff))

   // The free byte count never exceeds the size of the current chunk.
   `CBA_ASSERT_SAME(a_free_within_total, clock, reset, 1'b1, free_ff <= total_ff)

   // A cached translation always covers a nonempty range.
   `CBA_ASSERT_SAME(a_cache_range, clock, reset, cache_valid_ff, cache_low_ff < cache_high_ff)

   // A completed clear leaves an empty table and no cached translation.
   `CBA_ASSERT_NEXT(a_clear_empties, clock, reset,
      state_ff == cba_pkg::ST_SIMPLE && act_ff == cba_pkg::ACT_CLEAR && out_free,
      !cache_valid_ff && !opened_ff && cur_ff == '0 && free_ff == '0)

endmodule

`default_nettype wire
